@@ hw/rtl/opuq_pkg.sv @@
// Shared types and constants of the display page-update queue.
// No dependencies; the top level of the block imports this package.
`default_nettype none
package opuq_pkg;

   // Command kinds carried on the request tuser.
   localparam logic [2:0] KIND_SET_PIXEL   = 3'd0;
   localparam logic [2:0] KIND_CLEAR_BOX   = 3'd1;
   localparam logic [2:0] KIND_CLEAR_LAYER = 3'd2;
   localparam logic [2:0] KIND_SHOW_OVL    = 3'd3;
   localparam logic [2:0] KIND_HIDE_OVL    = 3'd4;
   localparam logic [2:0] KIND_POLL        = 3'd5;
   localparam logic [2:0] KIND_GRANTED     = 3'd6;
   localparam logic [2:0] KIND_XFER_DONE   = 3'd7;

   // Progress of a queued page update.
   localparam logic [2:0] ST_WAIT = 3'd0;
   localparam logic [2:0] ST_PAGE = 3'd1;
   localparam logic [2:0] ST_COL  = 3'd2;
   localparam logic [2:0] ST_DATA = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam logic [7:0] OP_PAGE   = 8'h22;
   localparam logic [7:0] OP_COLUMN = 8'h21;
   localparam logic [7:0] CTRL_CMD  = 8'h00;
   localparam logic [7:0] CTRL_DATA = 8'h40;

   localparam int QUEUE_DEPTH = 8;
   localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd60;

   // One queue entry as held in the request memory.
   typedef struct packed {
      logic [2:0] page;
      logic [6:0] col;
      logic [7:0] len;
      logic       lay;
      logic [2:0] st;
   } entry_type;

   // Result word, first member in the highest bits.
   typedef struct packed {
      logic       pad;
      logic       status;
      logic [7:0] slave_byte;
      logic [7:0] data_len;
      logic       data_layer;
      logic [9:0] data_offset;
      logic [7:0] cmd_byte2;
      logic [7:0] cmd_byte1;
      logic [7:0] cmd_byte0;
      logic [7:0] ctrl_byte;
      logic       xfer_start;
      logic       bus_release;
      logic       bus_request;
   } rsp_word_type;

endpackage
`default_nettype wire

@@ hw/rtl/opuq_ram.sv @@
// Single-port synchronous memory with registered read data.
// Self-contained; used for the frame store and the request queue.
`default_nettype none
module opuq_ram #(
   parameter int WIDTH     = 8,
   parameter int ADDR_BITS = 11
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [WIDTH-1:0]     wdata,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [2**ADDR_BITS];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule
`default_nettype wire

@@ hw/rtl/oled_page_update_queue_top.sv @@
// Top level of the display page-update queue: command sequencer, queue control
// and result register. Depends on opuq_pkg and opuq_ram.
`default_nettype none
//
//  Channel  | Direction | Handshake            | Contents
//  ---------+-----------+----------------------+-----------------------------------------
//  req_     | in        | req_tvalid/tready    | tuser: command kind; tdata: x, y, w, h, layer
//  rsp_     | out       | rsp_tvalid/tready    | tdata: one result word per command
//  csr_     | in        | csr_valid/ready      | csr_data: device bus address
//
// One command is worked on at a time. Bus granted searches the queue entries in turn.
// Set pixel rescans the whole page after the write, then searches the queue entries;
// clear box reads and rewrites each column of each page it covers; clearing a layer
// sweeps 1024 bytes. After reset a clearing pass zeroes the frame store; no word is
// accepted during it. A result waiting on rsp_ only holds back the loading of the next
// result.
module oled_page_update_queue_top #(
   parameter int SCREEN_WIDTH = 128,
   parameter int PAGE_COUNT   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] pos_x, [15:8] pos_y, [23:16] box_width, [31:24] box_height,
   // [32] layer, [39:33] zero
   input  logic [39:0] req_tdata,
   // [2:0] req_type
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] bus_request, [1] bus_release, [2] xfer_start, [10:3] ctrl_byte,
   // [18:11] cmd_byte0, [26:19] cmd_byte1, [34:27] cmd_byte2,
   // [44:35] data_offset, [45] data_layer, [53:46] data_len,
   // [61:54] slave_byte, [62] status, [63] zero
   output logic [63:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);
   import opuq_pkg::*;

   localparam logic [8:0] SW9   = 9'(SCREEN_WIDTH);
   localparam logic [7:0] SW8   = 8'(SCREEN_WIDTH);
   localparam logic [9:0] SW10  = 10'(SCREEN_WIDTH);
   localparam logic [8:0] ROWS9 = 9'(8 * PAGE_COUNT);
   localparam logic [3:0] PC4   = 4'(PAGE_COUNT);
   localparam logic [3:0] QD4   = 4'(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_PIX_WR, S_SCAN, S_BOX_RD, S_BOX_WR, S_BOX_NEXT,
      S_LAYER, S_ENQ_RD, S_ENQ_CHK, S_GRANT_RD, S_GRANT_CHK, S_DONE_RD,
      S_DONE_CHK, S_FINISH
   } state_type;

   state_type    state_ff, state_in;
   logic [10:0]  sweep_ff, sweep_in;
   logic [7:0]   x_ff, x_in, y_ff, y_in;
   logic         lay_ff, lay_in;
   logic [2:0]   page_ff, page_in;
   logic [7:0]   col_ff, col_in;
   logic [7:0]   xe_ff, xe_in;
   logic [6:0]   ye_ff, ye_in;
   logic         chk_v_ff, chk_v_in;
   logic [6:0]   chk_col_ff, chk_col_in;
   logic         found_ff, found_in;
   logic [6:0]   first_ff, first_in, last_ff, last_in;
   logic [6:0]   eq_col_ff, eq_col_in;
   logic [7:0]   eq_len_ff, eq_len_in;
   logic [3:0]   eq_i_ff, eq_i_in;
   logic [3:0]   idx_ff, idx_in;
   logic         ret_box_ff, ret_box_in;
   logic [2:0]   main_head_ff, main_head_in, ovl_head_ff, ovl_head_in;
   logic [3:0]   main_count_ff, main_count_in, ovl_count_ff, ovl_count_in;
   logic         shown_ff, shown_in, sending_ff, sending_in;
   logic [3:0]   slot_ff, slot_in;
   logic [6:0]   dev_ff, dev_in;
   rsp_word_type res_ff, res_in, rsp_data_ff, rsp_data_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic         fm_we;
   logic [10:0]  fm_addr;
   logic [7:0]   fm_wdata, fm_rdata;
   logic         rq_we;
   logic [3:0]   rq_addr;
   entry_type    rq_wdata, rq_rdata;

   logic [2:0]   lay_head;
   logic [3:0]   lay_count, act_count;
   logic [7:0]   box_mask;
   logic [2:0]   box_last_page;
   logic [8:0]   x_sum, y_sum;
   logic [7:0]   slave;
   logic [7:0]   in_x, in_y, in_w, in_h;
   logic         in_lay;
   logic [6:0]   ye_minus;

   // Frame store: bit n of the byte at {layer, page, column} is row 8*page+n.
   opuq_ram #(.WIDTH(8), .ADDR_BITS(11)) u_frame (
      .clock(clock), .we(fm_we), .addr(fm_addr), .wdata(fm_wdata), .rdata(fm_rdata)
   );

   // Request queue: main layer in entries 0 to 7, overlay in 8 to 15.
   opuq_ram #(.WIDTH($bits(entry_type)), .ADDR_BITS(4)) u_queue (
      .clock(clock), .we(rq_we), .addr(rq_addr), .wdata(rq_wdata), .rdata(rq_rdata)
   );

   assign in_x   = req_tdata[7:0];
   assign in_y   = req_tdata[15:8];
   assign in_w   = req_tdata[23:16];
   assign in_h   = req_tdata[31:24];
   assign in_lay = req_tdata[32];
   assign x_sum  = {1'b0, in_x} + {1'b0, in_w};
   assign y_sum  = {1'b0, in_y} + {1'b0, in_h};

   assign lay_head  = lay_ff ? ovl_head_ff : main_head_ff;
   assign lay_count = lay_ff ? ovl_count_ff : main_count_ff;
   assign act_count = shown_ff ? ovl_count_ff : main_count_ff;
   assign slave     = {dev_ff, 1'b0};
   assign ye_minus  = ye_ff - 7'd1;
   assign box_last_page = ye_minus[5:3];

   // Rows of the current page that fall inside the box are cleared.
   always_comb begin
      for (int n = 0; n < 8; n++) begin
         box_mask[n] = !(({2'b00, page_ff, 3'(n)} >= y_ff) &&
                         ({1'b0, page_ff, 3'(n)} < ye_ff));
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      lay_in        = lay_ff;
      page_in       = page_ff;
      col_in        = col_ff;
      xe_in         = xe_ff;
      ye_in         = ye_ff;
      chk_v_in      = chk_v_ff;
      chk_col_in    = chk_col_ff;
      found_in      = found_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      eq_col_in     = eq_col_ff;
      eq_len_in     = eq_len_ff;
      eq_i_in       = eq_i_ff;
      idx_in        = idx_ff;
      ret_box_in    = ret_box_ff;
      main_head_in  = main_head_ff;
      main_count_in = main_count_ff;
      ovl_head_in   = ovl_head_ff;
      ovl_count_in  = ovl_count_ff;
      shown_in      = shown_ff;
      sending_in    = sending_ff;
      slot_in       = slot_ff;
      dev_in        = dev_ff;
      res_in        = res_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      fm_we         = 1'b0;
      fm_addr       = {lay_ff, page_ff, col_ff[6:0]};
      fm_wdata      = 8'd0;
      rq_we         = 1'b0;
      rq_addr       = idx_ff;
      rq_wdata      = rq_rdata;

      if (csr_valid) begin
         dev_in = csr_data;
      end
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            fm_we   = 1'b1;
            fm_addr = sweep_ff;
            if (sweep_ff == '1) begin
               state_in = S_IDLE;
            end else begin
               sweep_in = sweep_ff + 11'd1;
            end
         end

         S_IDLE: begin
            if (req_tvalid) begin
               x_in       = in_x;
               y_in       = in_y;
               lay_in     = in_lay;
               res_in     = '0;
               eq_i_in    = 4'd0;
               col_in     = 8'd0;
               found_in   = 1'b0;
               chk_v_in   = 1'b0;
               sweep_in   = 11'd0;
               ret_box_in = 1'b0;
               state_in   = S_FINISH;
               case (req_tuser)
                  KIND_SET_PIXEL: begin
                     if ({1'b0, in_x} < SW9 && {1'b0, in_y} < ROWS9) begin
                        fm_addr  = {in_lay, in_y[5:3], in_x[6:0]};
                        page_in  = in_y[5:3];
                        state_in = S_PIX_WR;
                     end
                  end
                  KIND_CLEAR_BOX: begin
                     if ({1'b0, in_x} < SW9 && {1'b0, in_y} < ROWS9 &&
                         in_w != 8'd0 && in_h != 8'd0) begin
                        xe_in      = (x_sum > SW9) ? SW8 : x_sum[7:0];
                        ye_in      = (y_sum > ROWS9) ? ROWS9[6:0] : y_sum[6:0];
                        page_in    = in_y[5:3];
                        col_in     = in_x;
                        ret_box_in = 1'b1;
                        state_in   = S_BOX_RD;
                     end
                  end
                  KIND_CLEAR_LAYER: begin
                     state_in = S_LAYER;
                  end
                  KIND_SHOW_OVL: begin
                     lay_in   = 1'b1;
                     shown_in = 1'b1;
                     state_in = S_LAYER;
                  end
                  KIND_HIDE_OVL: begin
                     lay_in   = 1'b0;
                     shown_in = 1'b0;
                     state_in = S_LAYER;
                  end
                  KIND_POLL: begin
                     res_in.bus_request = !sending_ff && act_count != 4'd0;
                  end
                  KIND_GRANTED: begin
                     lay_in = shown_ff;
                     if (sending_ff) begin
                        res_in.status = 1'b1;
                     end else if (act_count != 4'd0) begin
                        state_in = S_GRANT_RD;
                     end
                  end
                  KIND_XFER_DONE: begin
                     state_in = S_DONE_RD;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end

         S_PIX_WR: begin
            fm_we    = 1'b1;
            fm_addr  = {lay_ff, page_ff, x_ff[6:0]};
            fm_wdata = fm_rdata | (8'd1 << y_ff[2:0]);
            state_in = S_SCAN;
         end

         // Reads run one column ahead of the nonzero check.
         S_SCAN: begin
            if ({1'b0, col_ff} < SW9) begin
               fm_addr    = {lay_ff, page_ff, col_ff[6:0]};
               chk_v_in   = 1'b1;
               chk_col_in = col_ff[6:0];
               col_in     = col_ff + 8'd1;
            end else begin
               chk_v_in = 1'b0;
            end
            if (chk_v_ff && fm_rdata != 8'd0) begin
               if (!found_ff) begin
                  first_in = chk_col_ff;
               end
               found_in = 1'b1;
               last_in  = chk_col_ff;
            end
            if ({1'b0, col_ff} >= SW9 && !chk_v_ff) begin
               if (found_ff) begin
                  eq_col_in = first_ff;
                  eq_len_in = {1'b0, last_ff - first_ff} + 8'd1;
                  state_in  = S_ENQ_RD;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         S_BOX_RD: begin
            state_in = S_BOX_WR;
         end

         S_BOX_WR: begin
            fm_we    = 1'b1;
            fm_wdata = fm_rdata & box_mask;
            if (col_ff + 8'd1 < xe_ff) begin
               col_in   = col_ff + 8'd1;
               state_in = S_BOX_RD;
            end else begin
               eq_col_in = x_ff[6:0];
               eq_len_in = xe_ff - x_ff;
               eq_i_in   = 4'd0;
               state_in  = S_ENQ_RD;
            end
         end

         S_BOX_NEXT: begin
            if (page_ff == box_last_page) begin
               state_in = S_FINISH;
            end else begin
               page_in  = page_ff + 3'd1;
               col_in   = x_ff;
               state_in = S_BOX_RD;
            end
         end

         // Zero the layer and queue every page of it in full.
         S_LAYER: begin
            fm_we   = 1'b1;
            fm_addr = {lay_ff, sweep_ff[9:0]};
            if (sweep_ff < 11'(PAGE_COUNT)) begin
               rq_we    = 1'b1;
               rq_addr  = {lay_ff, sweep_ff[2:0]};
               rq_wdata = '{page: sweep_ff[2:0], col: 7'd0, len: SW8,
                            lay: lay_ff, st: ST_WAIT};
            end
            if (sweep_ff[9:0] == '1) begin
               if (lay_ff) begin
                  ovl_head_in  = 3'd0;
                  ovl_count_in = PC4;
               end else begin
                  main_head_in  = 3'd0;
                  main_count_in = PC4;
               end
               state_in = S_FINISH;
            end else begin
               sweep_in = sweep_ff + 11'd1;
            end
         end

         S_ENQ_RD: begin
            if (eq_i_ff < lay_count) begin
               rq_addr  = {lay_ff, lay_head + eq_i_ff[2:0]};
               idx_in   = {lay_ff, lay_head + eq_i_ff[2:0]};
               state_in = S_ENQ_CHK;
            end else begin
               if (lay_count < QD4) begin
                  rq_we    = 1'b1;
                  rq_addr  = {lay_ff, lay_head + lay_count[2:0]};
                  rq_wdata = '{page: page_ff, col: eq_col_ff, len: eq_len_ff,
                               lay: lay_ff, st: ST_WAIT};
                  if (lay_ff) begin
                     ovl_count_in = ovl_count_ff + 4'd1;
                  end else begin
                     main_count_in = main_count_ff + 4'd1;
                  end
               end
               state_in = ret_box_ff ? S_BOX_NEXT : S_FINISH;
            end
         end

         S_ENQ_CHK: begin
            if (rq_rdata.page == page_ff && rq_rdata.lay == lay_ff &&
                rq_rdata.st == ST_WAIT) begin
               rq_we        = 1'b1;
               rq_wdata.col = eq_col_ff;
               rq_wdata.len = eq_len_ff;
               state_in     = ret_box_ff ? S_BOX_NEXT : S_FINISH;
            end else begin
               eq_i_in  = eq_i_ff + 4'd1;
               state_in = S_ENQ_RD;
            end
         end

         S_GRANT_RD: begin
            rq_addr  = {lay_ff, lay_head + eq_i_ff[2:0]};
            idx_in   = {lay_ff, lay_head + eq_i_ff[2:0]};
            state_in = S_GRANT_CHK;
         end

         S_GRANT_CHK: begin
            if (rq_rdata.st == ST_WAIT) begin
               rq_we             = 1'b1;
               rq_wdata.st       = ST_PAGE;
               slot_in           = idx_ff;
               sending_in        = 1'b1;
               res_in.xfer_start = 1'b1;
               res_in.ctrl_byte  = CTRL_CMD;
               res_in.cmd_byte0  = OP_PAGE;
               res_in.cmd_byte1  = {5'd0, rq_rdata.page};
               res_in.cmd_byte2  = {5'd0, rq_rdata.page};
               res_in.slave_byte = slave;
               state_in          = S_FINISH;
            end else if (eq_i_ff + 4'd1 < lay_count) begin
               eq_i_in  = eq_i_ff + 4'd1;
               state_in = S_GRANT_RD;
            end else begin
               state_in = S_FINISH;
            end
         end

         S_DONE_RD: begin
            rq_addr  = slot_ff;
            idx_in   = slot_ff;
            state_in = S_DONE_CHK;
         end

         S_DONE_CHK: begin
            state_in = S_FINISH;
            case (rq_rdata.st)
               ST_PAGE: begin
                  rq_we             = 1'b1;
                  rq_wdata.st       = ST_COL;
                  res_in.xfer_start = 1'b1;
                  res_in.ctrl_byte  = CTRL_CMD;
                  res_in.cmd_byte0  = OP_COLUMN;
                  res_in.cmd_byte1  = {1'b0, rq_rdata.col};
                  res_in.cmd_byte2  = {1'b0, rq_rdata.col} + rq_rdata.len - 8'd1;
                  res_in.slave_byte = slave;
               end
               ST_COL: begin
                  rq_we              = 1'b1;
                  rq_wdata.st        = ST_DATA;
                  res_in.xfer_start  = 1'b1;
                  res_in.ctrl_byte   = CTRL_DATA;
                  res_in.data_offset = 10'(rq_rdata.page) * SW10 + 10'(rq_rdata.col);
                  res_in.data_layer  = rq_rdata.lay;
                  res_in.data_len    = rq_rdata.len;
                  res_in.slave_byte  = slave;
               end
               ST_DATA: begin
                  rq_we              = 1'b1;
                  rq_wdata.st        = ST_DONE;
                  res_in.bus_release = 1'b1;
                  sending_in         = 1'b0;
                  if (rq_rdata.lay) begin
                     if (ovl_count_ff != 4'd0) begin
                        ovl_head_in  = ovl_head_ff + 3'd1;
                        ovl_count_in = ovl_count_ff - 4'd1;
                     end
                  end else begin
                     if (main_count_ff != 4'd0) begin
                        main_head_in  = main_head_ff + 3'd1;
                        main_count_in = main_count_ff - 4'd1;
                     end
                  end
               end
               default: begin
                  rq_we = 1'b0;
               end
            endcase
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         sweep_ff      <= 11'd0;
         rsp_valid_ff  <= 1'b0;
         main_head_ff  <= 3'd0;
         main_count_ff <= 4'd0;
         ovl_head_ff   <= 3'd0;
         ovl_count_ff  <= 4'd0;
         shown_ff      <= 1'b0;
         sending_ff    <= 1'b0;
         slot_ff       <= 4'd0;
         dev_ff        <= DEVICE_ADDRESS_RESET;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         rsp_valid_ff  <= rsp_valid_in;
         main_head_ff  <= main_head_in;
         main_count_ff <= main_count_in;
         ovl_head_ff   <= ovl_head_in;
         ovl_count_ff  <= ovl_count_in;
         shown_ff      <= shown_in;
         sending_ff    <= sending_in;
         slot_ff       <= slot_in;
         dev_ff        <= dev_in;
         x_ff          <= x_in;
         y_ff          <= y_in;
         lay_ff        <= lay_in;
         page_ff       <= page_in;
         col_ff        <= col_in;
         xe_ff         <= xe_in;
         ye_ff         <= ye_in;
         chk_v_ff      <= chk_v_in;
         chk_col_ff    <= chk_col_in;
         found_ff      <= found_in;
         first_ff      <= first_in;
         last_ff       <= last_in;
         eq_col_ff     <= eq_col_in;
         eq_len_ff     <= eq_len_in;
         eq_i_ff       <= eq_i_in;
         idx_ff        <= idx_in;
         ret_box_ff    <= ret_box_in;
         res_ff        <= res_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   // Neither queue ever holds more entries than it has slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      main_count_ff <= QD4 && ovl_count_ff <= QD4)
      else $error("queue count beyond depth");

   // Transfer fields stay zero in any word that issues no transfer.
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.xfer_start) |->
      (rsp_data_ff.ctrl_byte == 8'd0 && rsp_data_ff.cmd_byte0 == 8'd0 &&
       rsp_data_ff.data_len == 8'd0 && rsp_data_ff.slave_byte == 8'd0))
      else $error("transfer fields set without a transfer");

   // A command is taken only when the previous one has finished.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second command taken while busy");

endmodule
`default_nettype wire
